// ===== hdl/fbpa_pkg.sv =====
package fbpa_pkg;

    // Request kinds carried in the action field.
    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CHECK = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_START = 2'd2,
        STS_RSVD      = 2'd3
    } t_status;

    // Configuration register indexes.
    localparam logic REG_POOL_BASE   = 1'b0;
    localparam logic REG_BLOCK_BYTES = 1'b1;

    localparam logic [15:0] BLOCK_BYTES_RESET = 16'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new item and rewind the scan
        logic step;    // advance the scan to the next block
        logic commit;  // finish the item: update the map and the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;     // the current block ends the scan
        logic last;    // the current block is the final one
        logic none;    // the item has no work (unknown action)
    } t_dp_stat;

endpackage

// ===== hdl/fbpa_ctrl.sv =====
module fbpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  fbpa_pkg::t_dp_stat i_stat,
    output fbpa_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_done
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_finish;

    assign w_finish = i_stat.hit || i_stat.last || i_stat.none;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_finish) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_RESP;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_RESP);

endmodule

// ===== hdl/fbpa_dp.sv =====
module fbpa_dp #(
    parameter int NUM_BLOCKS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fbpa_pkg::t_dp_cmd  i_cmd,
    output fbpa_pkg::t_dp_stat o_stat,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_address,
    input  logic [31:0]        i_pool_base,
    input  logic [15:0]        i_block_bytes,
    output logic [1:0]         o_status,
    output logic [31:0]        o_granted_address,
    output logic               o_block_in_use,
    output logic [5:0]         o_free_blocks,
    output logic               o_any_free
);

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int TW = $clog2(NUM_BLOCKS + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(NUM_BLOCKS - 1);

    fbpa_pkg::t_action       r_act,     n_act;
    logic [31:0]             r_addr,    n_addr;
    logic [IW-1:0]           r_idx,     n_idx;
    logic [31:0]             r_start,   n_start;
    logic                    r_seen,    n_seen;
    logic [NUM_BLOCKS-1:0]   r_use_map, n_use_map;
    logic [TW-1:0]           r_tally,   n_tally;
    fbpa_pkg::t_status       r_status,  n_status;
    logic [31:0]             r_granted, n_granted;
    logic                    r_inuse,   n_inuse;

    logic                    w_match;
    logic                    w_cur_used;
    logic                    w_hit;
    logic [TW+5:0]           w_tally_ext;

    assign w_match    = (r_start == r_addr);
    assign w_cur_used = r_use_map[r_idx];

    always_comb begin
        unique case (r_act)
            fbpa_pkg::ACT_ALLOC: w_hit = !w_cur_used;
            fbpa_pkg::ACT_FREE:  w_hit = w_match;
            fbpa_pkg::ACT_CHECK: w_hit = w_match && w_cur_used;
            default:             w_hit = 1'b0;
        endcase
    end

    assign o_stat.hit  = w_hit;
    assign o_stat.last = (r_idx == IDX_LAST);
    assign o_stat.none = (r_act == fbpa_pkg::ACT_NONE);

    always_comb begin
        n_act     = r_act;
        n_addr    = r_addr;
        n_idx     = r_idx;
        n_start   = r_start;
        n_seen    = r_seen;
        n_use_map = r_use_map;
        n_tally   = r_tally;
        n_status  = r_status;
        n_granted = r_granted;
        n_inuse   = r_inuse;

        if (i_cmd.load) begin
            n_act   = fbpa_pkg::t_action'(i_action);
            n_addr  = i_address;
            n_idx   = '0;
            n_start = i_pool_base;
            n_seen  = 1'b0;
        end

        if (i_cmd.step) begin
            n_idx   = r_idx + IW'(1);
            n_start = r_start + {16'd0, i_block_bytes};
            n_seen  = r_seen || w_match;
        end

        if (i_cmd.commit) begin
            n_status  = fbpa_pkg::STS_OK;
            n_granted = '0;
            n_inuse   = 1'b0;
            unique case (r_act)
                fbpa_pkg::ACT_ALLOC: begin
                    if (w_hit) begin
                        n_use_map[r_idx] = 1'b1;
                        n_tally          = r_tally - TW'(1);
                        n_granted        = r_start;
                    end else begin
                        n_status = fbpa_pkg::STS_FULL;
                    end
                end
                fbpa_pkg::ACT_FREE: begin
                    if (w_hit) begin
                        // Freeing a block that is already free changes nothing.
                        if (w_cur_used) begin
                            n_use_map[r_idx] = 1'b0;
                            n_tally          = r_tally + TW'(1);
                        end
                    end else begin
                        n_status = fbpa_pkg::STS_NOT_START;
                    end
                end
                fbpa_pkg::ACT_CHECK: begin
                    if (!(r_seen || w_match)) begin
                        n_status = fbpa_pkg::STS_NOT_START;
                    end
                    n_inuse = w_hit;
                end
                default: begin
                    n_status = fbpa_pkg::STS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_map <= '0;
            r_tally   <= TW'(NUM_BLOCKS);
        end else begin
            r_use_map <= n_use_map;
            r_tally   <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_addr    <= n_addr;
        r_idx     <= n_idx;
        r_start   <= n_start;
        r_seen    <= n_seen;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_inuse   <= n_inuse;
    end

    assign w_tally_ext       = {6'd0, r_tally};
    assign o_status          = r_status;
    assign o_granted_address = r_granted;
    assign o_block_in_use    = r_inuse;
    assign o_free_blocks     = w_tally_ext[5:0];
    assign o_any_free        = (r_tally != '0);

endmodule

// ===== hdl/fixed_block_pool_allocator.sv =====
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-----------------------------------
// request   | in        | start, busy               | i_action, i_address
// result    | out       | o_done (one-cycle strobe) | o_status, o_granted_address,
//           |           |                           | o_block_in_use, o_free_blocks,
//           |           |                           | o_any_free
// config    | in        | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// An accepted item is scanned from the first block, and its result is strobed once
// the scan has visited k (1 to NUM_BLOCKS) blocks and reached the block that
// settles the request; one block is visited per cycle by a single 32-bit adder
// and comparator. busy stays high through the strobe cycle.
// Reset is synchronous and active low; it marks every block free and loads
// the registers with pool base 0 and block size 16. The receiver cannot stall.
module fixed_block_pool_allocator #(
    parameter int NUM_BLOCKS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_address,
    // Result channel.
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_granted_address,
    output logic        o_block_in_use,
    output logic [5:0]  o_free_blocks,
    output logic        o_any_free,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fbpa_pkg::t_dp_cmd  w_cmd;
    fbpa_pkg::t_dp_stat w_stat;

    logic [31:0] r_pool_base;
    logic [15:0] r_block_bytes;
    logic        w_wr;
    logic        w_reg_sel;

    // The registers are word aligned, so the word address bit selects one.
    assign w_reg_sel = paddr[2];
    assign w_wr      = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= '0;
            r_block_bytes <= fbpa_pkg::BLOCK_BYTES_RESET;
        end else if (w_wr) begin
            if (w_reg_sel == fbpa_pkg::REG_POOL_BASE) begin
                r_pool_base <= pwdata;
            end else begin
                r_block_bytes <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (w_reg_sel == fbpa_pkg::REG_BLOCK_BYTES) begin
            prdata = {16'd0, r_block_bytes};
        end else begin
            prdata = r_pool_base;
        end
    end

    // The controller sequences load, scan and commit; the datapath walks the
    // block starts one per cycle and holds the in-use map and the free count.
    fbpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    fbpa_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_action          (i_action),
        .i_address         (i_address),
        .i_pool_base       (r_pool_base),
        .i_block_bytes     (r_block_bytes),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_block_in_use    (o_block_in_use),
        .o_free_blocks     (o_free_blocks),
        .o_any_free        (o_any_free)
    );

`ifndef SYNTHESIS
    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // Every result is a single-cycle strobe.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // A full pool grants no address.
    a_full_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == fbpa_pkg::STS_FULL) |-> (o_granted_address == 32'd0))
        else $error("address granted while reporting a full pool");

    // A block reported in use must have been found at a block start.
    a_inuse_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_block_in_use) |-> (o_status == fbpa_pkg::STS_OK))
        else $error("block reported in use with a failing status");
`endif

endmodule
